@@ rtl/twbc_pkg.sv @@
// shared types and constants of the two-wheel balance controller
// no dependencies; imported by two_wheel_balance_controller
`timescale 1ns / 1ps
`default_nettype none

package twbc_pkg;

    // configuration port
    typedef logic [3:0]  cfg_addr_t;
    typedef logic [25:0] cfg_data_t;

    localparam cfg_addr_t CFG_OFFSET_START     = 4'd0;
    localparam cfg_addr_t CFG_OFFSET_WEIGHT    = 4'd1;
    localparam cfg_addr_t CFG_GAIN_RATE        = 4'd2;
    localparam cfg_addr_t CFG_GAIN_ANGLE       = 4'd3;
    localparam cfg_addr_t CFG_GAIN_POSITION    = 4'd4;
    localparam cfg_addr_t CFG_GAIN_WHEEL_SPEED = 4'd5;
    localparam cfg_addr_t CFG_GAIN_DRIVE       = 4'd6;
    localparam cfg_addr_t CFG_FALL_LIMIT_MS    = 4'd7;

    // register reset values
    localparam logic        [15:0] OFFSET_WEIGHT_RST    = 16'd33;
    localparam logic signed [23:0] GAIN_RATE_RST        = 24'sd75366;
    localparam logic signed [23:0] GAIN_ANGLE_RST       = 24'sd491520;
    localparam logic signed [23:0] GAIN_POSITION_RST    = 24'sd4588;
    localparam logic signed [23:0] GAIN_WHEEL_SPEED_RST = 24'sd6554;
    localparam logic signed [23:0] GAIN_DRIVE_RST       = -24'sd1311;
    localparam logic        [15:0] FALL_LIMIT_RST       = 16'd1000;

    // state reset values: 0.014 s in q8.24, -0.25 in q24.16
    localparam logic        [31:0] INTERVAL_INIT = 32'd234881;
    localparam logic signed [39:0] TILT_INIT     = -40'sd16384;

    // motor power limit in percent
    localparam logic signed [46:0] POWER_LIMIT = 47'sd100;

    // stream payload widths
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 16;

    // sequencer states
    typedef enum logic [19:0] {
        ST_IDLE      = 20'h00001,
        ST_IDIV_LOAD = 20'h00002,
        ST_DIV       = 20'h00004,
        ST_DIV_END   = 20'h00008,
        ST_EMA_MUL   = 20'h00010,
        ST_EMA_ACC   = 20'h00020,
        ST_TILT_MUL  = 20'h00040,
        ST_TILT_ACC  = 20'h00080,
        ST_POS       = 20'h00100,
        ST_WSUM      = 20'h00200,
        ST_DRV_MUL   = 20'h00400,
        ST_DRV_ACC   = 20'h00800,
        ST_SDIV_LOAD = 20'h01000,
        ST_T_LO      = 20'h02000,
        ST_T_HI      = 20'h04000,
        ST_T_ACC     = 20'h08000,
        ST_GD_MUL    = 20'h10000,
        ST_GD_ACC    = 20'h20000,
        ST_FIN       = 20'h40000,
        ST_OUT       = 20'h80000
    } state_t;

endpackage

`default_nettype wire

@@ rtl/two_wheel_balance_controller.sv @@
// Two-wheel balance controller: one control tick per input request.
//
// Input stream s_axis carries one control tick; the tick is taken when
// s_axis_tvalid and s_axis_tready are both high. s_axis_tready is high only
// while the sequencer is idle. Output stream m_axis carries left and right
// power and the fallen flag, one result per tick, held in an output
// register until m_axis_tready takes it; a stalled receiver keeps the
// next tick waiting in its final state, and the tick after that is not
// taken until the output register frees.
// The cfg channel writes one register per request (index, data); cfg_ready
// is always high and writes are meant for idle periods only.
// An inactive tick goes straight to the output state. An active tick
// runs the serial divider for the wheel speed and, after the first
// tick, for the loop interval too; its length is set by the
// one-bit-per-cycle divider, the single shared 34x34 multiplier and the
// window sum over W = SPEED_WINDOW entries.
// Reset (rst_n low, asynchronous) loads the register defaults, clears
// the tick count, the window and the position, and empties the output.
// Depends on twbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module two_wheel_balance_controller #(
    parameter int SPEED_WINDOW = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // tdata fields from bit 0: gyro_rate, left_count, right_count, now_ms,
    // drive, steer, zero pad
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [127:0]         s_axis_tdata,
    // tuser fields from bit 0: active
    input  logic                 s_axis_tuser,
    // tdata fields from bit 0: left motor power, right motor power
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,
    // tuser fields from bit 0: fallen
    output logic                 m_axis_tuser,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  twbc_pkg::cfg_addr_t  cfg_addr,
    input  twbc_pkg::cfg_data_t  cfg_data
);
    import twbc_pkg::*;

    localparam int SLOT_W = (SPEED_WINDOW > 1) ? $clog2(SPEED_WINDOW) : 1;
    localparam int WSUM_W = 33 + SLOT_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SPEED_WINDOW - 1);

    localparam logic signed [44:0] TILT_HI = (45'sd1 <<< 39) - 45'sd1;
    localparam logic signed [44:0] TILT_LO = -(45'sd1 <<< 39);
    localparam logic signed [49:0] WP_HI   = (50'sd1 <<< 47) - 50'sd1;
    localparam logic signed [49:0] WP_LO   = -(50'sd1 <<< 47);
    localparam logic signed [33:0] D_HI    = (34'sd1 <<< 32) - 34'sd1;
    localparam logic signed [33:0] D_LO    = -(34'sd1 <<< 32);

    // control and state registers
    state_t                    state_reg;
    logic               [31:0] tick_reg;
    logic               [31:0] first_time_reg;
    logic               [31:0] last_ok_reg;
    logic               [31:0] interval_reg;
    logic signed        [31:0] rate_offset_reg;
    logic signed        [39:0] tilt_reg;
    logic signed        [47:0] wheel_pos_reg;
    logic signed        [32:0] last_sum_reg;
    logic signed        [32:0] window_reg [SPEED_WINDOW];
    logic         [SLOT_W-1:0] slot_reg;
    logic         [SLOT_W-1:0] idx_reg;
    logic                [5:0] cnt_reg;
    logic                [1:0] term_k_reg;
    logic                      div_speed_reg;
    logic                      ovf_reg;
    logic                      m_valid_reg;

    // configuration registers
    logic               [15:0] offset_weight_reg;
    logic signed        [23:0] gain_rate_reg;
    logic signed        [23:0] gain_angle_reg;
    logic signed        [23:0] gain_position_reg;
    logic signed        [23:0] gain_wheel_speed_reg;
    logic signed        [23:0] gain_drive_reg;
    logic               [15:0] fall_limit_reg;

    // payload registers
    logic signed         [9:0] gyro_reg;
    logic signed        [31:0] left_reg;
    logic signed        [31:0] right_reg;
    logic               [31:0] now_reg;
    logic signed        [12:0] drive_reg;
    logic signed         [7:0] steer_reg;
    logic signed        [32:0] rate_reg;
    logic signed  [WSUM_W-1:0] wsum_reg;
    logic signed        [47:0] speed_reg;
    logic signed        [59:0] acc_reg;
    logic signed        [47:0] term_reg;
    logic signed        [67:0] prod_reg;
    logic               [42:0] rem_reg;
    logic               [46:0] low_reg;
    logic               [46:0] quo_reg;
    logic               [41:0] den_reg;
    logic signed         [7:0] res_left_reg;
    logic signed         [7:0] res_right_reg;
    logic                      res_fallen_reg;
    logic  [OUT_TDATA_W-1:0]   m_data_reg;
    logic                      m_user_reg;

    // handshakes
    logic accept;
    logic out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // tick counter saturates at all ones
    logic [31:0] tick_inc;
    logic        tick_full;
    assign tick_full = (tick_reg == 32'hFFFF_FFFF);
    assign tick_inc  = tick_full ? tick_reg : tick_reg + 32'd1;

    // shared multiplier operand selection
    logic signed [47:0] x_sel;
    logic signed [23:0] g_sel;
    logic signed [25:0] g16;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;

    assign g16 = $signed({gyro_reg, 16'h0000});

    always_comb
    begin
        case (term_k_reg)
            2'd0:    begin x_sel = 48'(rate_reg);      g_sel = gain_rate_reg;        end
            2'd1:    begin x_sel = 48'(tilt_reg);      g_sel = gain_angle_reg;       end
            2'd2:    begin x_sel = wheel_pos_reg;      g_sel = gain_position_reg;    end
            default: begin x_sel = speed_reg;          g_sel = gain_wheel_speed_reg; end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_EMA_MUL:
            begin
                mul_a = 34'(g16) - 34'(rate_offset_reg);
                mul_b = $signed({18'h0, offset_weight_reg});
            end
            ST_TILT_MUL:
            begin
                mul_a = 34'(rate_reg);
                mul_b = $signed({2'b00, interval_reg});
            end
            ST_DRV_MUL:
            begin
                mul_a = 34'(drive_reg);
                mul_b = $signed({2'b00, interval_reg});
            end
            ST_T_LO:
            begin
                mul_a = 34'(g_sel);
                mul_b = $signed({10'h000, x_sel[23:0]});
            end
            ST_T_HI:
            begin
                mul_a = 34'(g_sel);
                mul_b = 34'($signed(x_sel[47:24]));
            end
            ST_GD_MUL:
            begin
                mul_a = 34'(gain_drive_reg);
                mul_b = 34'(drive_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // offset average and corrected rate
    logic signed [33:0] ro_new;
    logic signed [32:0] rate_new;
    assign ro_new   = 34'(rate_offset_reg) + 34'(prod_reg >>> 16);
    assign rate_new = 33'(34'(g16) - ro_new);

    // tilt integration with saturation
    logic signed [44:0] tilt_sum;
    logic signed [39:0] tilt_next;
    assign tilt_sum  = 45'(tilt_reg) + 45'(prod_reg >>> 24);
    assign tilt_next = (tilt_sum > TILT_HI) ? 40'(TILT_HI) :
                       (tilt_sum < TILT_LO) ? 40'(TILT_LO) : 40'(tilt_sum);

    // encoder delta and wheel position
    logic signed [32:0] cnt_sum;
    logic signed [33:0] dsum;
    logic signed [32:0] delta;
    logic signed [49:0] wp_add;
    logic signed [49:0] wp_sub;
    logic signed [47:0] wp_add_next;
    logic signed [47:0] wp_sub_next;
    assign cnt_sum = 33'(left_reg) + 33'(right_reg);
    assign dsum    = 34'(cnt_sum) - 34'(last_sum_reg);
    assign delta   = (dsum > D_HI) ? 33'(D_HI) : (dsum < D_LO) ? 33'(D_LO) : 33'(dsum);
    assign wp_add  = 50'(wheel_pos_reg) + (50'(delta) <<< 16);
    assign wp_sub  = 50'(wheel_pos_reg) - 50'(prod_reg >>> 8);
    assign wp_add_next = (wp_add > WP_HI) ? 48'(WP_HI) :
                         (wp_add < WP_LO) ? 48'(WP_LO) : 48'(wp_add);
    assign wp_sub_next = (wp_sub > WP_HI) ? 48'(WP_HI) :
                         (wp_sub < WP_LO) ? 48'(WP_LO) : 48'(wp_sub);

    // divider operands
    logic              wsum_neg;
    logic [WSUM_W-1:0] ua;
    logic       [42:0] ua_hi;
    logic       [41:0] den_speed;
    logic       [41:0] den_int;
    logic       [31:0] dt;
    logic       [42:0] dt_hi;
    assign wsum_neg  = wsum_reg[WSUM_W-1];
    assign ua        = wsum_neg ? WSUM_W'(-wsum_reg) : WSUM_W'(wsum_reg);
    assign ua_hi     = 43'(ua >> 7);
    assign den_speed = 42'(interval_reg) * 42'(SPEED_WINDOW);
    assign den_int   = (42'(tick_reg) << 10) - (42'(tick_reg) << 4) - (42'(tick_reg) << 3);
    assign dt        = now_reg - first_time_reg;
    assign dt_hi     = 43'(dt >> 8);

    // one restoring step of the divider
    logic [42:0] div_try;
    logic [42:0] div_diff;
    logic        div_ge;
    assign div_try  = {rem_reg[41:0], low_reg[46]};
    assign div_ge   = (div_try >= {1'b0, den_reg});
    assign div_diff = div_try - {1'b0, den_reg};

    // speed quotient with sign and saturation
    logic        [46:0] speed_mag;
    logic signed [47:0] speed_next;
    assign speed_mag  = ovf_reg ? {47{1'b1}} : quo_reg;
    assign speed_next = wsum_neg ? -$signed(48'(speed_mag)) : $signed(48'(speed_mag));

    // one gain term: low and high partial products, floored at 2^-16
    logic signed [72:0] term_full;
    assign term_full = 73'(term_reg) + (73'($signed(prod_reg[47:0])) <<< 24);

    // power, truncated toward zero
    logic        [59:0] acc_abs;
    logic        [43:0] pmag;
    logic signed [45:0] power;
    logic               in_range;
    logic               late;
    logic        [31:0] elapsed;
    assign acc_abs  = acc_reg[59] ? 60'(-acc_reg) : 60'(acc_reg);
    assign pmag     = acc_abs[59:16];
    assign power    = acc_reg[59] ? -$signed(46'(pmag)) : $signed(46'(pmag));
    assign in_range = (47'(power) > -POWER_LIMIT) && (47'(power) < POWER_LIMIT);
    assign elapsed  = now_reg - last_ok_reg;
    assign late     = (elapsed >= 32'(fall_limit_reg));

    function automatic logic signed [7:0] clamp_power(input logic signed [46:0] p);
        logic signed [7:0] r;
        if (p > POWER_LIMIT)
            r = 8'(POWER_LIMIT);
        else if (p < -POWER_LIMIT)
            r = 8'(-POWER_LIMIT);
        else
            r = 8'(p);
        return r;
    endfunction

    logic signed [7:0] left_clamped;
    logic signed [7:0] right_clamped;
    assign left_clamped  = clamp_power(47'(power) + 47'(steer_reg));
    assign right_clamped = clamp_power(47'(power) - 47'(steer_reg));

    // output register fills from the sequencer and empties when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    // sequencer, state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            tick_reg             <= '0;
            first_time_reg       <= '0;
            last_ok_reg          <= '0;
            interval_reg         <= INTERVAL_INIT;
            rate_offset_reg      <= '0;
            tilt_reg             <= TILT_INIT;
            wheel_pos_reg        <= '0;
            last_sum_reg         <= '0;
            for (int i = 0; i < SPEED_WINDOW; i++)
                window_reg[i] <= '0;
            slot_reg             <= '0;
            idx_reg              <= '0;
            cnt_reg              <= '0;
            term_k_reg           <= '0;
            div_speed_reg        <= 1'b0;
            ovf_reg              <= 1'b0;
            offset_weight_reg    <= OFFSET_WEIGHT_RST;
            gain_rate_reg        <= GAIN_RATE_RST;
            gain_angle_reg       <= GAIN_ANGLE_RST;
            gain_position_reg    <= GAIN_POSITION_RST;
            gain_wheel_speed_reg <= GAIN_WHEEL_SPEED_RST;
            gain_drive_reg       <= GAIN_DRIVE_RST;
            fall_limit_reg       <= FALL_LIMIT_RST;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!s_axis_tuser)
                            state_reg <= ST_OUT;
                        else
                        begin
                            tick_reg <= tick_inc;
                            if (!tick_full)
                                slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                            if (tick_reg == '0)
                            begin
                                // first tick: fixed interval, position restart
                                interval_reg   <= INTERVAL_INIT;
                                first_time_reg <= s_axis_tdata[105:74];
                                last_ok_reg    <= s_axis_tdata[105:74];
                                wheel_pos_reg  <= '0;
                                last_sum_reg   <= '0;
                                for (int i = 0; i < SPEED_WINDOW; i++)
                                    window_reg[i] <= '0;
                                state_reg      <= ST_EMA_MUL;
                            end
                            else
                                state_reg <= ST_IDIV_LOAD;
                        end
                    end
                end
                ST_IDIV_LOAD:
                begin
                    div_speed_reg <= 1'b0;
                    cnt_reg       <= 6'd32;
                    ovf_reg       <= (dt_hi >= {1'b0, den_int});
                    state_reg     <= (dt_hi >= {1'b0, den_int}) ? ST_DIV_END : ST_DIV;
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= ST_DIV_END;
                end
                ST_DIV_END:
                begin
                    if (!div_speed_reg)
                    begin
                        interval_reg <= ovf_reg ? 32'hFFFF_FFFF : quo_reg[31:0];
                        state_reg    <= ST_EMA_MUL;
                    end
                    else
                    begin
                        term_k_reg <= 2'd0;
                        state_reg  <= ST_T_LO;
                    end
                end
                ST_EMA_MUL:
                    state_reg <= ST_EMA_ACC;
                ST_EMA_ACC:
                begin
                    rate_offset_reg <= 32'(ro_new);
                    state_reg       <= ST_TILT_MUL;
                end
                ST_TILT_MUL:
                    state_reg <= ST_TILT_ACC;
                ST_TILT_ACC:
                begin
                    tilt_reg  <= tilt_next;
                    state_reg <= ST_POS;
                end
                ST_POS:
                begin
                    last_sum_reg         <= cnt_sum;
                    wheel_pos_reg        <= wp_add_next;
                    window_reg[slot_reg] <= delta;
                    idx_reg              <= '0;
                    state_reg            <= ST_WSUM;
                end
                ST_WSUM:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == SLOT_LAST)
                        state_reg <= ST_DRV_MUL;
                end
                ST_DRV_MUL:
                    state_reg <= ST_DRV_ACC;
                ST_DRV_ACC:
                begin
                    wheel_pos_reg <= wp_sub_next;
                    state_reg     <= ST_SDIV_LOAD;
                end
                ST_SDIV_LOAD:
                begin
                    div_speed_reg <= 1'b1;
                    cnt_reg       <= 6'd47;
                    if (ua == '0)
                    begin
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_DIV_END;
                    end
                    else
                    begin
                        ovf_reg   <= (ua_hi >= {1'b0, den_speed});
                        state_reg <= (ua_hi >= {1'b0, den_speed}) ? ST_DIV_END : ST_DIV;
                    end
                end
                ST_T_LO:
                    state_reg <= ST_T_HI;
                ST_T_HI:
                    state_reg <= ST_T_ACC;
                ST_T_ACC:
                begin
                    term_k_reg <= term_k_reg + 2'd1;
                    state_reg  <= (term_k_reg == 2'd3) ? ST_GD_MUL : ST_T_LO;
                end
                ST_GD_MUL:
                    state_reg <= ST_GD_ACC;
                ST_GD_ACC:
                    state_reg <= ST_FIN;
                ST_FIN:
                begin
                    if (in_range)
                        last_ok_reg <= now_reg;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase

            // register writes
            if (cfg_valid)
            begin
                case (cfg_addr)
                    CFG_OFFSET_START:     rate_offset_reg      <= 32'($signed(cfg_data));
                    CFG_OFFSET_WEIGHT:    offset_weight_reg    <= cfg_data[15:0];
                    CFG_GAIN_RATE:        gain_rate_reg        <= $signed(cfg_data[23:0]);
                    CFG_GAIN_ANGLE:       gain_angle_reg       <= $signed(cfg_data[23:0]);
                    CFG_GAIN_POSITION:    gain_position_reg    <= $signed(cfg_data[23:0]);
                    CFG_GAIN_WHEEL_SPEED: gain_wheel_speed_reg <= $signed(cfg_data[23:0]);
                    CFG_GAIN_DRIVE:       gain_drive_reg       <= $signed(cfg_data[23:0]);
                    CFG_FALL_LIMIT_MS:    fall_limit_reg       <= cfg_data[15:0];
                    default:              ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 68'(mul_a * mul_b);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    gyro_reg       <= $signed(s_axis_tdata[9:0]);
                    left_reg       <= $signed(s_axis_tdata[41:10]);
                    right_reg      <= $signed(s_axis_tdata[73:42]);
                    now_reg        <= s_axis_tdata[105:74];
                    drive_reg      <= $signed(s_axis_tdata[118:106]);
                    steer_reg      <= $signed(s_axis_tdata[126:119]);
                    res_left_reg   <= '0;
                    res_right_reg  <= '0;
                    res_fallen_reg <= 1'b0;
                end
            end
            ST_IDIV_LOAD:
            begin
                rem_reg <= dt_hi;
                low_reg <= {dt[7:0], 39'h0};
                den_reg <= den_int;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= div_ge ? div_diff : div_try;
                low_reg <= {low_reg[45:0], 1'b0};
                quo_reg <= {quo_reg[45:0], div_ge};
            end
            ST_DIV_END:
            begin
                if (div_speed_reg)
                    speed_reg <= speed_next;
            end
            ST_EMA_ACC:
                rate_reg <= rate_new;
            ST_POS:
                wsum_reg <= '0;
            ST_WSUM:
                wsum_reg <= wsum_reg + WSUM_W'(window_reg[idx_reg]);
            ST_SDIV_LOAD:
            begin
                rem_reg <= ua_hi;
                low_reg <= {ua[6:0], 40'h0};
                den_reg <= den_speed;
                quo_reg <= '0;
                acc_reg <= '0;
            end
            ST_T_HI:
                term_reg <= $signed(prod_reg[47:0]);
            ST_T_ACC:
                acc_reg <= acc_reg + 60'(term_full >>> 16);
            ST_GD_ACC:
                acc_reg <= acc_reg + 60'(prod_reg);
            ST_FIN:
            begin
                if (!in_range && late)
                begin
                    res_left_reg   <= '0;
                    res_right_reg  <= '0;
                    res_fallen_reg <= 1'b1;
                end
                else
                begin
                    res_left_reg   <= left_clamped;
                    res_right_reg  <= right_clamped;
                    res_fallen_reg <= 1'b0;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_data_reg <= {res_right_reg, res_left_reg};
                    m_user_reg <= res_fallen_reg;
                end
            end
            default:
                ;
        endcase
    end

endmodule

`default_nettype wire
